@@ sv/psc_pkg.sv @@
// Shared types and constants for the clipped PID step block.
`timescale 1ns / 1ps
package psc_pkg;

    localparam int unsigned QBits    = 16;
    localparam int unsigned DataW    = 32;
    localparam int unsigned TicksW   = 16;
    localparam int unsigned LpfW     = 17;
    localparam int unsigned ClipW    = 31;
    localparam int unsigned AddrW    = 5;
    localparam int unsigned DivW     = 48;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_P_GAIN  = 3'd0,
        REG_I_GAIN  = 3'd1,
        REG_I_CLIP  = 3'd2,
        REG_D_GAIN  = 3'd3,
        REG_D_LPF   = 3'd4,
        REG_D_CLIP  = 3'd5,
        REG_OUT_MIN = 3'd6,
        REG_OUT_MAX = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] p_gain;
        logic signed [DataW-1:0] i_gain;
        logic [ClipW-1:0]        i_clip;
        logic signed [DataW-1:0] d_gain;
        logic [LpfW-1:0]         d_lpf;
        logic [ClipW-1:0]        d_clip;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
    } t_cfg;

    // Divider control and status between the sequencer and the divider.
    typedef struct packed {
        logic              start;
        logic [DivW-1:0]   dividend;
        logic [TicksW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quotient;
    } t_div_rsp;

endpackage

@@ sv/psc_if.sv @@
// Word channel interfaces for the PID step input and result.
`timescale 1ns / 1ps
interface psc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured;
    logic signed [31:0] goal;
    logic [15:0]        elapsed_ticks;
    modport source (output valid, measured, goal, elapsed_ticks, input ready);
    modport sink (input valid, measured, goal, elapsed_ticks, output ready);
endinterface

interface psc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               clamped;
    modport source (output valid, drive, clamped, input ready);
    modport sink (input valid, drive, clamped, output ready);
endinterface

@@ sv/psc_regs.sv @@
// APB configuration registers of the PID step block.
`timescale 1ns / 1ps
module psc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [psc_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output psc_pkg::t_cfg              o_cfg
);
    import psc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain  <= 32'sh0001_0000;
            r_cfg.i_gain  <= '0;
            r_cfg.i_clip  <= '1;
            r_cfg.d_gain  <= '0;
            r_cfg.d_lpf   <= '0;
            r_cfg.d_clip  <= '1;
            r_cfg.out_min <= 32'sh8000_0000;
            r_cfg.out_max <= 32'sh7FFF_FFFF;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_P_GAIN:  r_cfg.p_gain  <= pwdata;
                REG_I_GAIN:  r_cfg.i_gain  <= pwdata;
                REG_I_CLIP:  r_cfg.i_clip  <= pwdata[ClipW-1:0];
                REG_D_GAIN:  r_cfg.d_gain  <= pwdata;
                REG_D_LPF:   r_cfg.d_lpf   <= pwdata[LpfW-1:0];
                REG_D_CLIP:  r_cfg.d_clip  <= pwdata[ClipW-1:0];
                REG_OUT_MIN: r_cfg.out_min <= pwdata;
                REG_OUT_MAX: r_cfg.out_max <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_P_GAIN:  prdata = r_cfg.p_gain;
            REG_I_GAIN:  prdata = r_cfg.i_gain;
            REG_I_CLIP:  prdata = {1'b0, r_cfg.i_clip};
            REG_D_GAIN:  prdata = r_cfg.d_gain;
            REG_D_LPF:   prdata = {15'd0, r_cfg.d_lpf};
            REG_D_CLIP:  prdata = {1'b0, r_cfg.d_clip};
            REG_OUT_MIN: prdata = r_cfg.out_min;
            REG_OUT_MAX: prdata = r_cfg.out_max;
            default:     prdata = '0;
        endcase
    end
endmodule

@@ sv/psc_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psc_pkg::t_div_req   i_req,
    output psc_pkg::t_div_rsp   o_rsp
);
    import psc_pkg::*;

    localparam int unsigned CntW = $clog2(DivW + 1);

    logic [DivW-1:0]   r_quo;
    logic [TicksW:0]   r_rem;
    logic [TicksW-1:0] r_dvs;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TicksW:0]   w_shift;
    logic [TicksW:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem[TicksW-1:0], r_quo[DivW-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_shift;
            r_quo <= {r_quo[DivW-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CntW'(DivW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

@@ sv/pid_step_clipped.sv @@
// Top level of the clipped PID step: sequencer around one shared multiplier.
// Usage:
// Input words carry measured, goal and elapsed_ticks on i_in; one result word
// with drive and clamped leaves on o_out for every input word. Both channels
// use valid/ready and a word moves when both are high.
// The user must write gains, clips and clamps over the APB port only while
// the block idles; the block itself does not enforce this.
// From accept to result, the shared multiplier steps in states S_W1 to S_C4
// run up to the divide start, the divider takes its operands, a 48-bit
// serial divide of the derivative by the tick count runs, and states S_W7
// to S_C8 form the drive. The divider sets the latency.
// The block takes one word at a time; i_in.ready is high only between items.
// A finished result sits in the output register, and the next word may be
// accepted while it waits; that item stalls on its last step until the
// receiver takes the earlier result.
// Synchronous active-low reset returns state, config and divider control to
// reset values, clears integrator and filtered error, drops o_out.valid.
`timescale 1ns / 1ps
module pid_step_clipped (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [psc_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    psc_in_if.sink                    i_in,
    psc_out_if.source                 o_out
);
    import psc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_W1, S_C1, S_W2, S_C2, S_W3, S_C3, S_W4, S_C4,
        S_W5, S_C5, S_W6, S_C6, S_DIV, S_W7, S_C7, S_W8, S_C8
    } t_state;

    t_cfg     w_cfg;
    t_div_req r_div_req;
    t_div_rsp w_div_rsp;

    psc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    psc_div u_div (
        .i_clk, .i_rst_n, .i_req(r_div_req), .o_rsp(w_div_rsp)
    );

    t_state              r_state;
    logic signed [31:0]  r_err;
    logic [15:0]         r_ticks;
    logic signed [31:0]  r_acc;
    logic signed [31:0]  r_fpe;
    logic [15:0]         r_ml;
    logic signed [48:0]  r_inch;
    logic signed [49:0]  r_f;
    logic                r_dneg;
    logic [15:0]         r_sum_lo;
    logic signed [50:0]  r_hi;
    logic signed [32:0]  r_ma;
    logic signed [32:0]  r_mb;
    logic signed [65:0]  r_prod;
    logic signed [31:0]  r_drive;
    logic                r_clamped;
    logic                r_out_valid;

    logic signed [32:0]  w_diff_in;
    logic signed [31:0]  w_err_in;
    logic signed [65:0]  w_inc;
    logic signed [65:0]  w_acc_sum;
    logic signed [65:0]  w_ilim;
    logic signed [31:0]  w_acc_new;
    logic [65:0]         w_dmag;
    logic [16:0]         w_wt;
    logic [16:0]         w_wt_inv;
    logic signed [49:0]  w_fsum;
    logic signed [48:0]  w_deriv_raw;
    logic signed [48:0]  w_dlim;
    logic signed [48:0]  w_deriv;
    logic signed [33:0]  w_sum;
    logic signed [50:0]  w_drv;
    logic signed [50:0]  w_drv_lo;
    logic signed [50:0]  w_drv_hi;
    logic                w_hit_lo;
    logic                w_hit_hi;
    logic                w_out_free;

    // Input error, saturated to 32 bits.
    assign w_diff_in = 33'(i_in.goal) - 33'(i_in.measured);
    always_comb begin
        if (w_diff_in[32] != w_diff_in[31]) begin
            w_err_in = w_diff_in[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_err_in = w_diff_in[31:0];
        end
    end

    // Integrator update: (mh*t << 16) + ml*t, then symmetric clip.
    assign w_inc     = 66'($signed({r_inch, 16'd0})) + 66'($signed({1'b0, r_prod[33:0]}));
    assign w_acc_sum = w_inc + 66'(r_acc);
    assign w_ilim    = 66'($signed({1'b0, w_cfg.i_clip}));
    always_comb begin
        if (w_acc_sum > w_ilim) begin
            w_acc_new = 32'(w_ilim);
        end else if (w_acc_sum < -w_ilim) begin
            w_acc_new = 32'(-w_ilim);
        end else begin
            w_acc_new = w_acc_sum[31:0];
        end
    end

    assign w_dmag   = r_prod[65] ? 66'(-r_prod) : r_prod;
    assign w_wt     = (w_cfg.d_lpf > 17'h10000) ? 17'h10000 : w_cfg.d_lpf;
    assign w_wt_inv = 17'h10000 - w_wt;
    assign w_fsum   = r_f + 50'($signed(r_prod[48:0]));

    // Derivative: sign restored after the magnitude divide, then clipped; zero when r_ticks is zero.
    assign w_deriv_raw = r_dneg ? -$signed({1'b0, w_div_rsp.quotient})
                                :  $signed({1'b0, w_div_rsp.quotient});
    assign w_dlim = 49'($signed({1'b0, w_cfg.d_clip}));
    always_comb begin
        if (r_ticks == '0) begin
            w_deriv = '0;
        end else if (w_deriv_raw > w_dlim) begin
            w_deriv = w_dlim;
        end else if (w_deriv_raw < -w_dlim) begin
            w_deriv = -w_dlim;
        end else begin
            w_deriv = w_deriv_raw;
        end
    end
    assign w_sum = 34'(r_err) + 34'(r_acc) + 34'(w_deriv);

    // Drive and clamps; out_max is applied last and wins.
    assign w_drv    = r_hi + 51'($signed(r_prod[65:16]));
    assign w_hit_lo = w_drv < 51'(w_cfg.out_min);
    assign w_drv_lo = w_hit_lo ? 51'(w_cfg.out_min) : w_drv;
    assign w_hit_hi = w_drv_lo > 51'(w_cfg.out_max);
    assign w_drv_hi = w_hit_hi ? 51'(w_cfg.out_max) : w_drv_lo;

    assign w_out_free = !r_out_valid || o_out.ready;

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_acc           <= '0;
            r_fpe           <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_err   <= w_err_in;
                        r_ticks <= i_in.elapsed_ticks;
                        r_ma    <= 33'(w_cfg.i_gain);
                        r_mb    <= 33'(w_err_in);
                        r_state <= S_W1;
                    end
                end
                S_W1: r_state <= S_C1;
                S_C1: begin
                    r_ml    <= r_prod[31:16];
                    r_ma    <= 33'($signed(r_prod[63:32]));
                    r_mb    <= $signed({17'd0, r_ticks});
                    r_state <= S_W2;
                end
                S_W2: r_state <= S_C2;
                S_C2: begin
                    r_inch  <= r_prod[48:0];
                    r_ma    <= $signed({17'd0, r_ml});
                    r_mb    <= $signed({17'd0, r_ticks});
                    r_state <= S_W3;
                end
                S_W3: r_state <= S_C3;
                S_C3: begin
                    r_acc   <= w_acc_new;
                    r_ma    <= 33'(w_cfg.d_gain);
                    r_mb    <= 33'(r_err) - 33'(r_fpe);
                    r_state <= S_W4;
                end
                S_W4: r_state <= S_C4;
                S_C4: begin
                    r_dneg             <= r_prod[65];
                    r_div_req.start    <= 1'b1;
                    r_div_req.dividend <= w_dmag[63:16];
                    r_div_req.divisor  <= r_ticks;
                    r_ma    <= $signed({16'd0, w_wt_inv});
                    r_mb    <= 33'(r_err);
                    r_state <= S_W5;
                end
                S_W5: r_state <= S_C5;
                S_C5: begin
                    r_f     <= r_prod[49:0];
                    r_ma    <= $signed({16'd0, w_wt});
                    r_mb    <= 33'(r_fpe);
                    r_state <= S_W6;
                end
                S_W6: r_state <= S_C6;
                S_C6: begin
                    r_fpe   <= w_fsum[47:16];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_sum_lo <= w_sum[15:0];
                        r_ma     <= 33'(w_cfg.p_gain);
                        r_mb     <= 33'($signed(w_sum[33:16]));
                        r_state  <= S_W7;
                    end
                end
                S_W7: r_state <= S_C7;
                S_C7: begin
                    r_hi    <= r_prod[50:0];
                    r_ma    <= 33'(w_cfg.p_gain);
                    r_mb    <= $signed({17'd0, r_sum_lo});
                    r_state <= S_W8;
                end
                S_W8: r_state <= S_C8;
                S_C8: begin
                    if (w_out_free) begin
                        r_drive     <= w_drv_hi[31:0];
                        r_clamped   <= w_hit_lo || w_hit_hi;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_drive;
    assign o_out.clamped = r_clamped;
endmodule

@@ sv/psc_chk.sv @@
// Port-level assertions for the PID step block, bound to the top level.
`timescale 1ns / 1ps
module psc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_drive,
    input logic        i_out_clamped
);
    // Busy after taking a word.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready while an item is in work");

    // No result can show up in the cycle after a word is taken.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result too early");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_drive) && $stable(i_out_clamped))
        else $error("stalled result changed");

    // Reset drops the result.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind pid_step_clipped psc_chk u_psc_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_drive(o_out.drive),
    .i_out_clamped(o_out.clamped)
);

@@ tb/tb_psc_checker.sv @@
// Checker for the clipped PID step: tracks register writes, predicts results, compares.
`timescale 1ns / 1ps
module tb_psc_checker
    import psc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [AddrW-1:0]     paddr,
    input  logic [31:0]          pwdata,
    psc_in_if                    in_mon,
    psc_out_if                   out_mon,
    output int                   fail_cnt,
    output int                   pending_cnt,
    output int                   result_cnt
);

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
    } t_drive_word;

    localparam longint QOne   = 65536;
    localparam longint MaxS32 = 64'sd2147483647;
    localparam longint MinS32 = -64'sd2147483648;

    longint m_p_gain, m_i_gain, m_i_clip, m_d_gain, m_d_lpf, m_d_clip;
    longint m_out_min, m_out_max;
    longint m_integ, m_filt_err;
    t_drive_word drive_q[$];

    initial begin
        fail_cnt = 0;
        result_cnt = 0;
    end
    assign pending_cnt = drive_q.size();

    function automatic longint clip_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Arithmetic shift of a signed 64-bit value rounds toward minus infinity.
    function automatic longint floor_q16(input longint x);
        return x >>> 16;
    endfunction

    function automatic t_drive_word predict_drive(input logic signed [31:0] meas,
                                                  input logic signed [31:0] goal,
                                                  input logic [15:0] ticks_in);
        t_drive_word res;
        longint err, ticks, deriv, w, sum, hi, lo, drv;
        ticks = longint'(ticks_in);
        err = longint'(goal) - longint'(meas);
        if (err > MaxS32) err = MaxS32;
        if (err < MinS32) err = MinS32;
        m_integ = clip_sym(m_integ + floor_q16(m_i_gain * err) * ticks, m_i_clip);
        if (ticks == 0)
            deriv = 0;
        else
            deriv = clip_sym((m_d_gain * (err - m_filt_err)) / (ticks * QOne), m_d_clip);
        w = (m_d_lpf > QOne) ? QOne : m_d_lpf;
        m_filt_err = floor_q16((QOne - w) * err + w * m_filt_err);
        sum = err + m_integ + deriv;
        hi = floor_q16(sum);
        lo = sum - hi * QOne;
        drv = m_p_gain * hi + floor_q16(m_p_gain * lo);
        res.clamped = 1'b0;
        if (drv < m_out_min) begin
            drv = m_out_min;
            res.clamped = 1'b1;
        end
        if (drv > m_out_max) begin
            drv = m_out_max;
            res.clamped = 1'b1;
        end
        res.drive = drv[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_drive_word got, want;
        if (!i_rst_n) begin
            m_p_gain   <= QOne;
            m_i_gain   <= 0;
            m_i_clip   <= MaxS32;
            m_d_gain   <= 0;
            m_d_lpf    <= 0;
            m_d_clip   <= MaxS32;
            m_out_min  <= MinS32;
            m_out_max  <= MaxS32;
            m_integ    = 0;
            m_filt_err = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_P_GAIN:  m_p_gain  <= longint'($signed(pwdata));
                    REG_I_GAIN:  m_i_gain  <= longint'($signed(pwdata));
                    REG_I_CLIP:  m_i_clip  <= longint'({1'b0, pwdata[30:0]});
                    REG_D_GAIN:  m_d_gain  <= longint'($signed(pwdata));
                    REG_D_LPF:   m_d_lpf   <= longint'({1'b0, pwdata[16:0]});
                    REG_D_CLIP:  m_d_clip  <= longint'({1'b0, pwdata[30:0]});
                    REG_OUT_MIN: m_out_min <= longint'($signed(pwdata));
                    REG_OUT_MAX: m_out_max <= longint'($signed(pwdata));
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                drive_q.push_back(predict_drive(in_mon.measured, in_mon.goal,
                                                in_mon.elapsed_ticks));
            if (out_mon.valid && out_mon.ready) begin
                result_cnt++;
                got.drive = out_mon.drive;
                got.clamped = out_mon.clamped;
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result drive=%h", got.drive));
                end else begin
                    want = drive_q.pop_front();
                    if (got.drive !== want.drive)
                        report_mismatch($sformatf("drive %h, predicted %h",
                                                  got.drive, want.drive));
                    if (got.clamped !== want.clamped)
                        report_mismatch($sformatf("clamped %b, predicted %b",
                                                  got.clamped, want.clamped));
                end
            end
        end
    end

endmodule

@@ tb/tb_pid_step_clipped.sv @@
// Testbench top for the clipped PID step: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_pid_step_clipped;
    import psc_pkg::*;

    localparam int IdleLimit = 20000;
    localparam int RandPhases = 10;
    localparam int ItemsPerPhase = 150;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AddrW-1:0]   paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_cnt, pending_cnt, result_cnt;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 idle_cycles = 0;
    int                 sent_cnt = 0;

    psc_in_if  in_ch ();
    psc_out_if out_ch ();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.measured = '0;
        in_ch.goal = '0;
        in_ch.elapsed_ticks = '0;
        out_ch.ready = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pid_step_clipped dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tb_psc_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt),
        .result_cnt  (result_cnt)
    );

    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // The run is stuck if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit) begin
            $display("timeout: no word moved in %0d cycles", IdleLimit);
            $display("== FAIL ==");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] m, input logic [31:0] g,
                             input logic [15:0] t);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.measured      <= m;
        in_ch.goal          <= g;
        in_ch.elapsed_ticks <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    // Block sits idle once every result is back and the divider has had time to settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] v [8]);
        for (int k = 0; k < 8; k++) reg_write(t_reg_idx'(k), v[k]);
    endtask

    function automatic logic [31:0] pick_cfg(input int k);
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) return $urandom;
        if (kind == 1) return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        if (kind == 2 && k != 0) return 32'h0;
        case (t_reg_idx'(k))
            REG_P_GAIN:  return $urandom_range(32'h30000) - 32'h18000;
            REG_I_GAIN:  return $urandom_range(32'h8000) - 32'h4000;
            REG_I_CLIP:  return $urandom_range(32'h200000);
            REG_D_GAIN:  return $urandom_range(32'h40000) - 32'h20000;
            REG_D_LPF:   return ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                        : $urandom_range(65536);
            REG_D_CLIP:  return $urandom_range(32'h200000);
            REG_OUT_MIN: return -$urandom_range(32'h100000);
            default:     return $urandom_range(32'h100000);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(32'h80000) - 32'h40000;
        endcase
    endfunction

    function automatic logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'($urandom);
        if (r == 2) return 16'hffff;
        return 16'($urandom_range(8, 1));
    endfunction

    initial begin
        logic [31:0] cfg [8];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: saturating errors and tick extremes.
        send_word(32'h8000_0000, 32'h7fff_ffff, 16'd1);
        send_word(32'h7fff_ffff, 32'h8000_0000, 16'd1);
        send_word(32'h0, 32'h0, 16'd0);
        send_word(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        send_word(32'h0, 32'h0001_0000, 16'd3);
        send_word(32'h0, 32'h8000_0000, 16'd0);
        drain_results();

        // Crossed clamps, zero clips and a weight above one.
        cfg = '{32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0001_ffff,
                32'h0, 32'h0001_0000, 32'hffff_0000};
        write_all(cfg);
        send_word(32'h0, 32'h0003_0000, 16'd1);
        send_word(32'h0005_0000, 32'h0, 16'd2);
        send_word(32'h0, 32'h0, 16'd0);
        send_word(32'h0, 32'h0000_8000, 16'd5);
        drain_results();

        // Gains and clips at their extremes.
        cfg = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        write_all(cfg);
        send_word(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        send_word(32'h7fff_ffff, 32'h8000_0000, 16'd1);
        send_word(32'h0, 32'h0, 16'd0);
        send_word(32'h1234_5678, 32'h8765_4321, 16'd7);
        cfg = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000};
        drain_results();
        write_all(cfg);
        send_word(32'h0, 32'h0001_0000, 16'd1);
        send_word(32'h8000_0000, 32'h0, 16'd0);
        send_word(32'h0, 32'h7fff_ffff, 16'hffff);
        drain_results();

        for (int ph = 0; ph < RandPhases; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            for (int k = 0; k < 8; k++) cfg[k] = pick_cfg(k);
            write_all(cfg);
            for (int n = 0; n < ItemsPerPhase; n++)
                send_word(pick_value(), pick_value(), pick_ticks());
            drain_results();
        end

        $display("Sent %0d words and checked %0d results over %0d register settings.",
                 sent_cnt, result_cnt, RandPhases + 3);
        $display("Idling mixes: none, sender 57%%, receiver 57%%, both 18%%.");
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
